FILE: design/microwire_eeprom_master_assert.svh
// Assertion macros used by the checker of the Microwire EEPROM master.
`ifndef MICROWIRE_EEPROM_MASTER_ASSERT_SVH
`define MICROWIRE_EEPROM_MASTER_ASSERT_SVH

// Implication checked at every rising edge outside of reset.
`define MWE_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication whose consequence is checked at the next rising edge.
`define MWE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/mwe_pkg.sv
// Types and constants of the Microwire EEPROM master.
package mwe_pkg;

   // Command codes on the request channel.
   localparam logic [2:0] CMD_EWEN  = 3'd0;
   localparam logic [2:0] CMD_EWDS  = 3'd1;
   localparam logic [2:0] CMD_ERAL  = 3'd2;
   localparam logic [2:0] CMD_ERASE = 3'd3;
   localparam logic [2:0] CMD_WRAL  = 3'd4;
   localparam logic [2:0] CMD_WRITE = 3'd5;
   localparam logic [2:0] CMD_READ  = 3'd6;
   localparam logic [2:0] CMD_NONE  = 3'd7;

   // Device opcodes that follow the start bit.
   localparam logic [1:0] OP_CTRL  = 2'b00;
   localparam logic [1:0] OP_WRITE = 2'b01;
   localparam logic [1:0] OP_READ  = 2'b10;
   localparam logic [1:0] OP_ERASE = 2'b11;

   // Control codes placed in the top two address bits.
   localparam logic [1:0] CTRL_EWEN = 2'b11;
   localparam logic [1:0] CTRL_EWDS = 2'b00;
   localparam logic [1:0] CTRL_ERAL = 2'b10;
   localparam logic [1:0] CTRL_WRAL = 2'b01;

   // Configuration register indexes.
   localparam logic CSR_WORD_16BIT = 1'b0;
   localparam logic CSR_SIZE_CODE  = 1'b1;

   localparam int CSR_DATA_W = 3;

   typedef enum logic [5:0] {
      PH_IDLE  = 6'b000001,
      PH_SEND  = 6'b000010,
      PH_READ  = 6'b000100,
      PH_CSLOW = 6'b001000,
      PH_WAIT  = 6'b010000,
      PH_END   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic        chip_select;
      logic        serial_clock;
      logic        data_in_pin;
      logic        busy_res;
      logic        done_res;
      logic        refused;
      logic [15:0] read_data;
      logic        write_enabled;
   } rsp_type;

endpackage

FILE: design/mwe_if.sv
// Request and response channel interfaces of the Microwire EEPROM master.
interface mwe_req_if;
   logic        valid;
   logic        ready;
   logic        start_req;
   logic [2:0]  command;
   logic [10:0] address;
   logic [15:0] write_data;
   logic        do_level;

   modport source (output valid, start_req, command, address, write_data, do_level,
                   input ready);
   modport sink (input valid, start_req, command, address, write_data, do_level,
                 output ready);
endinterface

interface mwe_rsp_if;
   logic        valid;
   logic        ready;
   logic        chip_select;
   logic        serial_clock;
   logic        data_in_pin;
   logic        busy_res;
   logic        done_res;
   logic        refused;
   logic [15:0] read_data;
   logic        write_enabled;

   modport source (output valid, chip_select, serial_clock, data_in_pin, busy_res,
                   done_res, refused, read_data, write_enabled, input ready);
   modport sink (input valid, chip_select, serial_clock, data_in_pin, busy_res,
                 done_res, refused, read_data, write_enabled, output ready);
endinterface

FILE: design/microwire_eeprom_master.sv
// Top level of the Microwire (three-wire) serial EEPROM master.
//
//   Channel   Direction  Handshake            Contents
//   req_chan  in         valid/ready          start_req, command, address, write_data, do_level
//   rsp_chan  out        valid/ready          pin levels, busy, done, refused, read data, enable
//   csr_*     in         csr_we, no wait      word_16bit (index 0), size_code (index 1)
//
// Each request transfer is one tick of the serial sequencer and yields exactly one response
// transfer, registered in the cycle after acceptance. One request is taken every cycle; the only
// limit is the single result register, which frees up in the cycle its content is taken.
// Reset is synchronous and active high: the sequencer returns to idle with erase/write
// disabled and the result register empty. A stalled response only holds back new requests.
module microwire_eeprom_master #(
   parameter int MAX_ADDR_BITS = 11
) (
   input  logic                             clock,
   input  logic                             reset,
   mwe_req_if.sink                          req_chan,
   mwe_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [mwe_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int SHIFT_W = MAX_ADDR_BITS + 19;
   localparam int CNT_W   = $clog2(SHIFT_W + 1);

   logic               word_16bit_ff;
   logic [2:0]         size_code_ff;
   logic [SHIFT_W-1:0] frame;
   logic [CNT_W-1:0]   frame_len;
   logic               accept;
   logic               can_load;
   mwe_pkg::rsp_type   result;
   mwe_pkg::rsp_type   rsp_data;

   // Configuration registers; writes must arrive only while the block is idle, which the block itself does not enforce.
   always_ff @(posedge clock) begin
      if (reset) begin
         word_16bit_ff <= 1'b1;
         size_code_ff  <= 3'd0;
      end else if (csr_we) begin
         unique case (csr_index)
            mwe_pkg::CSR_WORD_16BIT: word_16bit_ff <= csr_wdata[0];
            mwe_pkg::CSR_SIZE_CODE:  size_code_ff  <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = can_load;
   assign accept         = req_chan.valid && can_load;

   // The frame is built from the request fields while the sequencer decides whether
   // this tick actually starts a command.
   mwe_frame #(
      .MAX_ADDR_BITS(MAX_ADDR_BITS)
   ) u_frame (
      .word_16bit (word_16bit_ff),
      .size_code  (size_code_ff),
      .command    (req_chan.command),
      .address    (req_chan.address),
      .write_data (req_chan.write_data),
      .frame      (frame),
      .frame_len  (frame_len)
   );

   // The sequencer state advances only on an accepted tick.
   mwe_seq #(
      .MAX_ADDR_BITS(MAX_ADDR_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .word_16bit (word_16bit_ff),
      .start_req  (req_chan.start_req),
      .command    (req_chan.command),
      .do_level   (req_chan.do_level),
      .frame      (frame),
      .frame_len  (frame_len),
      .result     (result)
   );

   mwe_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .result    (result),
      .rsp_ready (rsp_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_data  (rsp_data),
      .can_load  (can_load)
   );

   assign rsp_chan.chip_select   = rsp_data.chip_select;
   assign rsp_chan.serial_clock  = rsp_data.serial_clock;
   assign rsp_chan.data_in_pin   = rsp_data.data_in_pin;
   assign rsp_chan.busy_res      = rsp_data.busy_res;
   assign rsp_chan.done_res      = rsp_data.done_res;
   assign rsp_chan.refused       = rsp_data.refused;
   assign rsp_chan.read_data     = rsp_data.read_data;
   assign rsp_chan.write_enabled = rsp_data.write_enabled;

endmodule

FILE: design/mwe_frame.sv
// Command frame builder: start bit, opcode, address or control code, write data.
module mwe_frame #(
   parameter int MAX_ADDR_BITS = 11
) (
   input  logic                                   word_16bit,
   input  logic [2:0]                             size_code,
   input  logic [2:0]                             command,
   input  logic [10:0]                            address,
   input  logic [15:0]                            write_data,
   output logic [MAX_ADDR_BITS+18:0]              frame,
   output logic [$clog2(MAX_ADDR_BITS+20)-1:0]    frame_len
);

   localparam int SHIFT_W = MAX_ADDR_BITS + 19;
   localparam int CNT_W   = $clog2(SHIFT_W + 1);

   logic [3:0]         awidth_raw;
   logic [3:0]         awidth;
   logic [10:0]        amask;
   logic [10:0]        addr_masked;
   logic [1:0]         opcode;
   logic [SHIFT_W-1:0] field;
   logic [SHIFT_W-1:0] head;
   logic               has_data;

   always_comb begin
      awidth_raw = word_16bit ? 4'd6 : 4'd7;
      if (size_code == 3'd1 || size_code == 3'd2) begin
         awidth_raw = awidth_raw + 4'd2;
      end else if (size_code == 3'd3 || size_code == 3'd4) begin
         awidth_raw = awidth_raw + 4'd4;
      end
      awidth = (awidth_raw > 4'(MAX_ADDR_BITS)) ? 4'(MAX_ADDR_BITS) : awidth_raw;
   end

   // At the full eleven bits the shift wraps to zero and the subtraction gives all ones.
   assign amask       = (11'd1 << awidth) - 11'd1;
   assign addr_masked = address & amask;

   always_comb begin
      has_data = 1'b0;
      unique case (command)
         mwe_pkg::CMD_EWEN: begin
            opcode = mwe_pkg::OP_CTRL;
            field  = SHIFT_W'(mwe_pkg::CTRL_EWEN) << (awidth - 4'd2);
         end
         mwe_pkg::CMD_EWDS: begin
            opcode = mwe_pkg::OP_CTRL;
            field  = SHIFT_W'(mwe_pkg::CTRL_EWDS) << (awidth - 4'd2);
         end
         mwe_pkg::CMD_ERAL: begin
            opcode = mwe_pkg::OP_CTRL;
            field  = SHIFT_W'(mwe_pkg::CTRL_ERAL) << (awidth - 4'd2);
         end
         mwe_pkg::CMD_ERASE: begin
            opcode = mwe_pkg::OP_ERASE;
            field  = SHIFT_W'(addr_masked);
         end
         mwe_pkg::CMD_WRAL: begin
            opcode   = mwe_pkg::OP_CTRL;
            field    = SHIFT_W'(mwe_pkg::CTRL_WRAL) << (awidth - 4'd2);
            has_data = 1'b1;
         end
         mwe_pkg::CMD_WRITE: begin
            opcode   = mwe_pkg::OP_WRITE;
            field    = SHIFT_W'(addr_masked);
            has_data = 1'b1;
         end
         default: begin
            opcode = mwe_pkg::OP_READ;
            field  = SHIFT_W'(addr_masked);
         end
      endcase
   end

   assign head = (SHIFT_W'(1) << (awidth + 4'd2)) | (SHIFT_W'(opcode) << awidth) | field;

   always_comb begin
      frame     = head;
      frame_len = CNT_W'(awidth) + CNT_W'(3);
      if (has_data) begin
         if (word_16bit) begin
            frame     = (head << 16) | SHIFT_W'(write_data);
            frame_len = frame_len + CNT_W'(16);
         end else begin
            frame     = (head << 8) | SHIFT_W'(write_data[7:0]);
            frame_len = frame_len + CNT_W'(8);
         end
      end
   end

endmodule

FILE: design/mwe_seq.sv
// Bit-level sequencer: phase state, bit counter, shifters and pin levels per tick.
module mwe_seq #(
   parameter int MAX_ADDR_BITS = 11
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic                                word_16bit,
   input  logic                                start_req,
   input  logic [2:0]                          command,
   input  logic                                do_level,
   input  logic [MAX_ADDR_BITS+18:0]           frame,
   input  logic [$clog2(MAX_ADDR_BITS+20)-1:0] frame_len,
   output mwe_pkg::rsp_type                    result
);

   localparam int SHIFT_W = MAX_ADDR_BITS + 19;
   localparam int CNT_W   = $clog2(SHIFT_W + 1);
   localparam int IDX_W   = $clog2(SHIFT_W);

   mwe_pkg::phase_type phase_ff, phase_in, phase_c;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, cnt_c;
   logic               half_ff, half_in, half_c;
   logic [SHIFT_W-1:0] shift_ff, shift_in, shift_c;
   logic [15:0]        rdata_ff, rdata_in;
   logic [2:0]         cmd_ff, cmd_in, cmd_c;
   logic               flag_ff, flag_in;
   logic               is_erase_write;

   assign is_erase_write = (command == mwe_pkg::CMD_ERAL) || (command == mwe_pkg::CMD_ERASE) ||
                           (command == mwe_pkg::CMD_WRAL) || (command == mwe_pkg::CMD_WRITE);

   always_comb begin
      phase_c  = phase_ff;
      cnt_c    = cnt_ff;
      half_c   = half_ff;
      shift_c  = shift_ff;
      cmd_c    = cmd_ff;
      result   = '0;

      // A new command is only taken while idle.
      if (phase_ff == mwe_pkg::PH_IDLE && start_req && command != mwe_pkg::CMD_NONE) begin
         if (is_erase_write && !flag_ff) begin
            result.done_res = 1'b1;
            result.refused  = 1'b1;
         end else begin
            phase_c = mwe_pkg::PH_SEND;
            cnt_c   = frame_len;
            half_c  = 1'b0;
            shift_c = frame;
            cmd_c   = command;
         end
      end

      phase_in = phase_c;
      cnt_in   = cnt_c;
      half_in  = half_c;
      shift_in = shift_c;
      cmd_in   = cmd_c;
      rdata_in = rdata_ff;
      flag_in  = flag_ff;

      unique case (phase_c)
         mwe_pkg::PH_SEND: begin
            result.chip_select  = 1'b1;
            result.busy_res     = 1'b1;
            result.serial_clock = half_c;
            if (cnt_c != '0) begin
               result.data_in_pin = shift_c[IDX_W'(cnt_c - CNT_W'(1))];
            end
            half_in = ~half_c;
            if (half_c && cnt_c != '0) begin
               cnt_in = cnt_c - CNT_W'(1);
            end
            if (cnt_in == '0) begin
               half_in = 1'b0;
               if (cmd_c == mwe_pkg::CMD_READ) begin
                  cnt_in   = word_16bit ? CNT_W'(16) : CNT_W'(8);
                  rdata_in = '0;
                  phase_in = mwe_pkg::PH_READ;
               end else if (cmd_c == mwe_pkg::CMD_EWEN || cmd_c == mwe_pkg::CMD_EWDS) begin
                  phase_in = mwe_pkg::PH_END;
               end else begin
                  phase_in = mwe_pkg::PH_CSLOW;
               end
            end
         end
         mwe_pkg::PH_READ: begin
            result.chip_select = 1'b1;
            result.busy_res    = 1'b1;
            if (!half_c) begin
               result.serial_clock = 1'b1;
               rdata_in            = {rdata_ff[14:0], do_level};
               half_in             = 1'b1;
            end else begin
               half_in = 1'b0;
               if (cnt_c != '0) begin
                  cnt_in = cnt_c - CNT_W'(1);
               end
               if (cnt_in == '0) begin
                  phase_in = mwe_pkg::PH_END;
               end
            end
         end
         mwe_pkg::PH_CSLOW: begin
            result.busy_res = 1'b1;
            phase_in        = mwe_pkg::PH_WAIT;
         end
         mwe_pkg::PH_WAIT: begin
            result.chip_select = 1'b1;
            result.busy_res    = 1'b1;
            if (do_level) begin
               phase_in = mwe_pkg::PH_END;
            end
         end
         mwe_pkg::PH_END: begin
            result.done_res = 1'b1;
            if (cmd_c == mwe_pkg::CMD_EWEN) begin
               flag_in = 1'b1;
            end else if (cmd_c == mwe_pkg::CMD_EWDS) begin
               flag_in = 1'b0;
            end
            phase_in = mwe_pkg::PH_IDLE;
         end
         default: begin
            phase_in = mwe_pkg::PH_IDLE;
         end
      endcase

      result.read_data     = rdata_in;
      result.write_enabled = flag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= mwe_pkg::PH_IDLE;
         cnt_ff   <= '0;
         half_ff  <= 1'b0;
         shift_ff <= '0;
         rdata_ff <= '0;
         cmd_ff   <= mwe_pkg::CMD_EWEN;
         flag_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         half_ff  <= half_in;
         shift_ff <= shift_in;
         rdata_ff <= rdata_in;
         cmd_ff   <= cmd_in;
         flag_ff  <= flag_in;
      end
   end

endmodule

FILE: design/mwe_out_reg.sv
// Result register between the sequencer and the response channel.
module mwe_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  mwe_pkg::rsp_type result,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output mwe_pkg::rsp_type rsp_data,
   output logic             can_load
);

   logic             valid_ff, valid_in;
   mwe_pkg::rsp_type data_ff;

   // The slot frees up in the same cycle that its content is taken.
   assign can_load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: design/mwe_checker.sv
// Port-level checker for the Microwire EEPROM master, with its bind statement.
`include "microwire_eeprom_master_assert.svh"

module mwe_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic chip_select,
   input logic serial_clock,
   input logic busy_res,
   input logic done_res,
   input logic refused
);

   `MWE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `MWE_ASSERT_IMPLY(a_done_not_busy, clock, reset, rsp_valid && done_res, !busy_res, "done together with busy")
   `MWE_ASSERT_IMPLY(a_refused_done, clock, reset, rsp_valid && refused, done_res && !chip_select, "refused without done")
   `MWE_ASSERT_IMPLY(a_cs_busy, clock, reset, rsp_valid && chip_select, busy_res, "chip select outside a command")
   `MWE_ASSERT_IMPLY(a_sk_cs, clock, reset, rsp_valid && serial_clock, chip_select, "serial clock without chip select")

endmodule

bind microwire_eeprom_master mwe_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .chip_select  (rsp_chan.chip_select),
   .serial_clock (rsp_chan.serial_clock),
   .busy_res     (rsp_chan.busy_res),
   .done_res     (rsp_chan.done_res),
   .refused      (rsp_chan.refused)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the Microwire EEPROM master: stimulus, predictor and checker.
`timescale 1ns / 1ps

// One sequencer tick as it travels on the request channel.
typedef struct packed {
   logic        start;
   logic [2:0]  cmd;
   logic [10:0] addr;
   logic [15:0] wdata;
   logic        dol;
} tick_type;

// Tracks the serial sequencer tick by tick and checks every response against it.
class eeprom_scoreboard #(int unsigned MAX_ABITS = 11);
   logic               word16;
   logic [2:0]         size_sel;
   logic               ew_enabled;
   mwe_pkg::phase_type seq_phase;
   logic [4:0]         bits_left;
   logic               sk_high;
   logic [29:0]        frame_bits;
   logic [15:0]        gathered;
   logic [2:0]         active_cmd;
   mwe_pkg::rsp_type   pin_states_q[$];
   int                 errors;

   function new();
      word16     = 1'b1;
      size_sel   = 3'd0;
      ew_enabled = 1'b0;
      seq_phase  = mwe_pkg::PH_IDLE;
      bits_left  = '0;
      sk_high    = 1'b0;
      frame_bits = '0;
      gathered   = '0;
      active_cmd = mwe_pkg::CMD_EWEN;
      errors     = 0;
   endfunction

   function void set_csr(logic idx, logic [2:0] value);
      if (idx == mwe_pkg::CSR_WORD_16BIT)
         word16 = value[0];
      else
         size_sel = value;
   endfunction

   // Address width of the selected device; unknown size codes act as the smallest part.
   function int unsigned addr_bits();
      int unsigned a;
      a = word16 ? 6 : 7;
      if (size_sel == 3'd1 || size_sel == 3'd2)
         a += 2;
      else if (size_sel == 3'd3 || size_sel == 3'd4)
         a += 4;
      if (a > MAX_ABITS)
         a = MAX_ABITS;
      return a;
   endfunction

   function mwe_pkg::rsp_type advance(tick_type t);
      mwe_pkg::rsp_type r;
      int unsigned      a;
      int unsigned      len;
      logic [1:0]       op;
      logic [10:0]      field;
      logic [10:0]      amask;
      logic [63:0]      frame;
      r = '0;
      if (seq_phase == mwe_pkg::PH_IDLE && t.start && t.cmd != mwe_pkg::CMD_NONE) begin
         if (t.cmd >= mwe_pkg::CMD_ERAL && t.cmd <= mwe_pkg::CMD_WRITE && !ew_enabled) begin
            r.done_res = 1'b1;
            r.refused  = 1'b1;
         end else begin
            a     = addr_bits();
            amask = 11'((1 << a) - 1);
            len   = 3 + a;
            case (t.cmd)
               mwe_pkg::CMD_EWEN: begin
                  op    = mwe_pkg::OP_CTRL;
                  field = 11'(mwe_pkg::CTRL_EWEN) << (a - 2);
               end
               mwe_pkg::CMD_EWDS: begin
                  op    = mwe_pkg::OP_CTRL;
                  field = 11'(mwe_pkg::CTRL_EWDS) << (a - 2);
               end
               mwe_pkg::CMD_ERAL: begin
                  op    = mwe_pkg::OP_CTRL;
                  field = 11'(mwe_pkg::CTRL_ERAL) << (a - 2);
               end
               mwe_pkg::CMD_ERASE: begin
                  op    = mwe_pkg::OP_ERASE;
                  field = t.addr & amask;
               end
               mwe_pkg::CMD_WRAL: begin
                  op    = mwe_pkg::OP_CTRL;
                  field = 11'(mwe_pkg::CTRL_WRAL) << (a - 2);
               end
               mwe_pkg::CMD_WRITE: begin
                  op    = mwe_pkg::OP_WRITE;
                  field = t.addr & amask;
               end
               default: begin
                  op    = mwe_pkg::OP_READ;
                  field = t.addr & amask;
               end
            endcase
            frame = (64'd1 << (a + 2)) | (64'(op) << a) | 64'(field);
            if (t.cmd == mwe_pkg::CMD_WRAL || t.cmd == mwe_pkg::CMD_WRITE) begin
               if (word16) begin
                  frame = (frame << 16) | 64'(t.wdata);
                  len += 16;
               end else begin
                  frame = (frame << 8) | 64'(t.wdata[7:0]);
                  len += 8;
               end
            end
            frame_bits = frame[29:0];
            bits_left  = len[4:0];
            sk_high    = 1'b0;
            active_cmd = t.cmd;
            seq_phase  = mwe_pkg::PH_SEND;
         end
      end

      case (seq_phase)
         mwe_pkg::PH_SEND: begin
            r.chip_select  = 1'b1;
            r.busy_res     = 1'b1;
            r.serial_clock = sk_high;
            if (bits_left != 0)
               r.data_in_pin = frame_bits[bits_left - 5'd1];
            if (!sk_high) begin
               sk_high = 1'b1;
            end else begin
               sk_high = 1'b0;
               if (bits_left != 0)
                  bits_left--;
            end
            if (bits_left == 0) begin
               sk_high = 1'b0;
               if (active_cmd == mwe_pkg::CMD_READ) begin
                  bits_left = word16 ? 5'd16 : 5'd8;
                  gathered  = '0;
                  seq_phase = mwe_pkg::PH_READ;
               end else if (active_cmd == mwe_pkg::CMD_EWEN ||
                            active_cmd == mwe_pkg::CMD_EWDS) begin
                  seq_phase = mwe_pkg::PH_END;
               end else begin
                  seq_phase = mwe_pkg::PH_CSLOW;
               end
            end
         end
         mwe_pkg::PH_READ: begin
            r.chip_select = 1'b1;
            r.busy_res    = 1'b1;
            if (!sk_high) begin
               r.serial_clock = 1'b1;
               gathered       = {gathered[14:0], t.dol};
               sk_high        = 1'b1;
            end else begin
               sk_high = 1'b0;
               if (bits_left != 0)
                  bits_left--;
               if (bits_left == 0)
                  seq_phase = mwe_pkg::PH_END;
            end
         end
         mwe_pkg::PH_CSLOW: begin
            r.busy_res = 1'b1;
            seq_phase  = mwe_pkg::PH_WAIT;
         end
         mwe_pkg::PH_WAIT: begin
            r.chip_select = 1'b1;
            r.busy_res    = 1'b1;
            if (t.dol)
               seq_phase = mwe_pkg::PH_END;
         end
         mwe_pkg::PH_END: begin
            r.done_res = 1'b1;
            if (active_cmd == mwe_pkg::CMD_EWEN)
               ew_enabled = 1'b1;
            else if (active_cmd == mwe_pkg::CMD_EWDS)
               ew_enabled = 1'b0;
            seq_phase = mwe_pkg::PH_IDLE;
         end
         default: seq_phase = mwe_pkg::PH_IDLE;
      endcase

      r.read_data     = gathered;
      r.write_enabled = ew_enabled;
      return r;
   endfunction

   function void note_tick(tick_type t);
      pin_states_q.push_back(advance(t));
   endfunction

   function string show(mwe_pkg::rsp_type r);
      return $sformatf("cs=%b sk=%b di=%b busy=%b done=%b refused=%b data=%h we=%b",
                       r.chip_select, r.serial_clock, r.data_in_pin, r.busy_res,
                       r.done_res, r.refused, r.read_data, r.write_enabled);
   endfunction

   function void check_rsp(mwe_pkg::rsp_type got);
      mwe_pkg::rsp_type want;
      if (pin_states_q.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("mismatch at %0t: response with no tick pending: %s", $time, show(got));
         return;
      end
      want = pin_states_q.pop_front();
      if (got !== want) begin
         errors++;
         if (errors <= 10) begin
            $display("mismatch at %0t: expected %s", $time, show(want));
            $display("                      actual   %s", show(got));
         end
      end
   endfunction

   function bit pending();
      return pin_states_q.size() != 0;
   endfunction

   function bit busy();
      return seq_phase != mwe_pkg::PH_IDLE;
   endfunction

   function bit waiting();
      return seq_phase == mwe_pkg::PH_WAIT;
   endfunction

   function void close_out();
      errors += pin_states_q.size();
   endfunction
endclass

module tb_top;
   localparam int MAX_ADDR_BITS = 11;
   localparam int ITEM_TARGET   = 1900;
   localparam int PHASE_TICKS   = 125;
   localparam int NO_CUT        = 1000000;
   localparam int CYCLE_LIMIT   = 400000;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic             csr_index;
   logic [2:0]       csr_wdata;

   mwe_req_if req_bus();
   mwe_rsp_if rsp_bus();

   eeprom_scoreboard #(MAX_ADDR_BITS) sb;

   // Knobs shared by the driver tasks and the response-side stall process.
   int  gap_odds;
   bit  no_idling;
   int  ticks_sent;
   int  cycle_count = 0;
   int  stall_left  = 0;
   bit  stall_mode  = 1'b1;

   microwire_eeprom_master #(.MAX_ADDR_BITS(MAX_ADDR_BITS)) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // The response side stalls in bursts of random length. The mode bit flips now and then
   // so that long stretches with no back-pressure alternate with stretches full of it.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left    <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (!no_idling && stall_mode && $urandom_range(0, 5) == 0)
            stall_left <= $urandom_range(1, 16);
      end
      if ($urandom_range(0, 99) == 0)
         stall_mode <= ($urandom_range(0, 2) != 0);
   end

   // Every response transfer is compared with the oldest predicted pin state.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_rsp({rsp_bus.chip_select, rsp_bus.serial_clock, rsp_bus.data_in_pin,
                       rsp_bus.busy_res, rsp_bus.done_res, rsp_bus.refused,
                       rsp_bus.read_data, rsp_bus.write_enabled});
   end

   // Presents one tick and waits for its transfer. The sender may first back off for a
   // burst of idle cycles; valid only drops when such a gap is actually taken, so it never
   // sees two updates in the same time step.
   task automatic send_tick(input tick_type t);
      if (!no_idling && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.start_req  <= t.start;
      req_bus.command    <= t.cmd;
      req_bus.address    <= t.addr;
      req_bus.write_data <= t.wdata;
      req_bus.do_level   <= t.dol;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_tick(t);
      ticks_sent++;
      if (ticks_sent >= ITEM_TARGET - 250)
         no_idling = 1'b1;
   endtask

   // Issues one command and keeps ticking until the sequencer is idle again, or until
   // tick_cap ticks have gone by, which leaves the command unfinished on purpose. While
   // the device is busy programming, DO stays low for ready_delay ticks and then rises.
   // Filler ticks carry random content, with an occasional start that must be ignored.
   task automatic run_command(input logic [2:0] cmd, input logic [10:0] addr,
                              input logic [15:0] wdata, input int ready_delay,
                              input int tick_cap);
      tick_type t;
      int       waited;
      int       n;
      t.start = 1'b1;
      t.cmd   = cmd;
      t.addr  = addr;
      t.wdata = wdata;
      t.dol   = $urandom_range(0, 1);
      send_tick(t);
      waited = 0;
      n      = 1;
      while (sb.busy() && n < tick_cap) begin
         t.start = ($urandom_range(0, 7) == 0);
         t.cmd   = 3'($urandom_range(0, 7));
         t.addr  = 11'($urandom_range(0, 2047));
         t.wdata = 16'($urandom_range(0, 65535));
         if (sb.waiting()) begin
            t.dol = (waited >= ready_delay);
            waited++;
         end else begin
            t.dol = $urandom_range(0, 1);
         end
         send_tick(t);
         n++;
      end
   endtask

   task automatic write_csr(input logic idx, input logic [2:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_csr(idx, value);
   endtask

   // Registers change only with no transfer outstanding. The sequencer itself may still be
   // in the middle of a command, which checks that the frame already built is kept.
   task automatic apply_config(input bit w16, input logic [2:0] sel);
      req_bus.valid <= 1'b0;
      while (sb.pending()) @(posedge clock);
      write_csr(mwe_pkg::CSR_WORD_16BIT, {2'($urandom_range(0, 3)), w16});
      write_csr(mwe_pkg::CSR_SIZE_CODE, sel);
      csr_we <= 1'b0;
   endtask

   function automatic logic [2:0] pick_command();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return mwe_pkg::CMD_READ;
      if (r < 50) return mwe_pkg::CMD_WRITE;
      if (r < 60) return mwe_pkg::CMD_ERASE;
      if (r < 66) return mwe_pkg::CMD_ERAL;
      if (r < 72) return mwe_pkg::CMD_WRAL;
      if (r < 88) return mwe_pkg::CMD_EWEN;
      return mwe_pkg::CMD_EWDS;
   endfunction

   function automatic logic [10:0] pick_address();
      case ($urandom_range(0, 7))
         0:       return 11'h000;
         1:       return 11'h7FF;
         default: return 11'($urandom_range(0, 2047));
      endcase
   endfunction

   function automatic logic [15:0] pick_data();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Settings visited by the random phases: both word sizes at the smallest and the
   // largest part, a few in between, and size codes that the block does not know.
   bit         phase_w16  [10] = '{0, 0, 1, 1, 0, 1, 0, 1, 0, 1};
   logic [2:0] phase_size [10] = '{0, 4, 4, 2, 1, 3, 5, 7, 6, 0};

   initial begin
      tick_type noise;
      int       target;
      int       delay;

      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = mwe_pkg::CSR_WORD_16BIT;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.start_req  = 1'b0;
      req_bus.command    = mwe_pkg::CMD_NONE;
      req_bus.address    = '0;
      req_bus.write_data = '0;
      req_bus.do_level   = 1'b0;
      rsp_bus.ready      = 1'b1;
      gap_odds           = 0;
      no_idling          = 1'b0;
      ticks_sent         = 0;
      sb                 = new();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset setting. Erase/write starts out disabled, so the first
      // four commands must be refused on the spot.
      gap_odds = 6;
      run_command(mwe_pkg::CMD_ERASE, 11'h7FF, 16'h0000, 0, NO_CUT);
      run_command(mwe_pkg::CMD_WRITE, 11'h7FF, 16'hFFFF, 0, NO_CUT);
      run_command(mwe_pkg::CMD_ERAL, 11'h000, 16'h0000, 0, NO_CUT);
      run_command(mwe_pkg::CMD_WRAL, 11'h000, 16'hFFFF, 0, NO_CUT);
      // An unknown command and a plain idle tick leave the sequencer alone.
      run_command(mwe_pkg::CMD_NONE, 11'h555, 16'h5555, 0, NO_CUT);
      noise = '{start: 1'b0, cmd: mwe_pkg::CMD_READ, addr: 11'h2AA, wdata: 16'hAAAA,
                dol: 1'b1};
      send_tick(noise);
      // Reads are allowed while disabled.
      run_command(mwe_pkg::CMD_READ, 11'h000, 16'h0000, 0, NO_CUT);
      run_command(mwe_pkg::CMD_EWEN, 11'h000, 16'h0000, 0, NO_CUT);
      run_command(mwe_pkg::CMD_WRITE, 11'h7FF, 16'hFFFF, 0, NO_CUT);
      run_command(mwe_pkg::CMD_WRITE, 11'h000, 16'h0000, 3, NO_CUT);
      run_command(mwe_pkg::CMD_ERASE, 11'h7FF, 16'h0000, 1, NO_CUT);
      run_command(mwe_pkg::CMD_ERAL, 11'h000, 16'h0000, 2, NO_CUT);
      run_command(mwe_pkg::CMD_WRAL, 11'h000, 16'hA5A5, 0, NO_CUT);
      run_command(mwe_pkg::CMD_READ, 11'h7FF, 16'hFFFF, 0, NO_CUT);
      run_command(mwe_pkg::CMD_EWDS, 11'h7FF, 16'h0000, 0, NO_CUT);
      run_command(mwe_pkg::CMD_WRITE, 11'h123, 16'h1234, 0, NO_CUT);
      run_command(mwe_pkg::CMD_EWEN, 11'h000, 16'h0000, 0, NO_CUT);

      // Random part: one phase per setting, mostly complete commands with random content,
      // with some noise ticks and long programming waits mixed in.
      for (int p = 0; p < 10; p++) begin
         if (p == 9)
            apply_config(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
         else
            apply_config(phase_w16[p], phase_size[p]);
         target = ticks_sent + PHASE_TICKS;
         while (ticks_sent < target) begin
            gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 12);
            delay    = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 5);
            if ($urandom_range(0, 99) < 8) begin
               repeat ($urandom_range(1, 3)) begin
                  noise.start = $urandom_range(0, 1);
                  noise.cmd   = noise.start ? mwe_pkg::CMD_NONE : 3'($urandom_range(0, 7));
                  noise.addr  = 11'($urandom_range(0, 2047));
                  noise.wdata = 16'($urandom_range(0, 65535));
                  noise.dol   = $urandom_range(0, 1);
                  send_tick(noise);
               end
            end else begin
               run_command(pick_command(), pick_address(), pick_data(), delay, NO_CUT);
            end
         end
         // Now and then the next setting lands while a command is still on the wire.
         if (p < 9 && $urandom_range(0, 1) == 1)
            run_command(pick_command(), pick_address(), pick_data(), 3,
                        $urandom_range(2, 30));
      end

      // Let the last responses drain and the pipeline settle.
      req_bus.valid <= 1'b0;
      while (sb.pending()) @(posedge clock);
      repeat (4) @(posedge clock);
      sb.close_out();
      if (sb.errors == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end
endmodule
